// ===== rtl/core/spi_request_frame_receiver_crc8_top_defines.svh =====
// Assertion macros shared by the SPI request frame receiver RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SPI_REQUEST_FRAME_RECEIVER_CRC8_TOP_DEFINES_SVH
`define SPI_REQUEST_FRAME_RECEIVER_CRC8_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SRFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled during reset.
`define SRFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== rtl/core/srfr_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the SPI request receiver.
// No dependencies.
package srfr_pkg;

    localparam int unsigned DataW = 8;
    localparam int unsigned WordW = 16;
    localparam int unsigned KindW = 2;
    localparam int unsigned StatusW = 2;
    localparam int unsigned IndexW = 3;

    localparam int unsigned STdataW = 8;
    localparam int unsigned STuserW = 3;
    localparam int unsigned MTdataW = 64;

    localparam logic [DataW-1:0] CrcPoly = 8'h07;
    localparam logic [DataW-1:0] CrcMsb  = 8'h80;
    localparam logic [DataW-1:0] TxWait  = 8'd100;
    localparam logic [DataW-1:0] TxIdle  = 8'd0;
    localparam logic [DataW-1:0] RxAck   = 8'd101;
    localparam logic [DataW-1:0] RxOk    = 8'd102;

    localparam logic CmdStart = 1'b0;
    localparam logic CmdByte  = 1'b1;

    localparam logic [KindW-1:0] KindHello    = 2'd0;
    localparam logic [KindW-1:0] KindThrottle = 2'd1;
    localparam logic [KindW-1:0] KindVoltage  = 2'd2;

    localparam logic [IndexW-1:0] ThrottleBytes = 3'd6;
    localparam logic [IndexW-1:0] VoltageBytes  = 3'd2;

    localparam logic [StatusW-1:0] StOk    = 2'd0;
    localparam logic [StatusW-1:0] StNoAck = 2'd1;
    localparam logic [StatusW-1:0] StCrc   = 2'd2;

    typedef struct packed {
        logic               command;
        logic [KindW-1:0]   msg_kind;
        logic [DataW-1:0]   rx_byte;
    } item_t;

    typedef struct packed {
        logic [DataW-1:0]   tx_byte;
        logic               frame_done;
        logic [StatusW-1:0] status;
        logic [WordW-1:0]   motor_left;
        logic [WordW-1:0]   motor_right;
        logic [WordW-1:0]   voltage;
    } result_t;

    // CRC-8, MSB first, one byte per call: eight shallow shift/xor steps.
    function automatic logic [DataW-1:0] crc8_byte(input logic [DataW-1:0] acc,
                                                   input logic [DataW-1:0] din);
        logic [DataW-1:0] d;
        d = acc ^ din;
        for (int i = 0; i < 8; i++) begin
            if ((d & CrcMsb) != '0) begin
                d = {d[DataW-2:0], 1'b0} ^ CrcPoly;
            end else begin
                d = {d[DataW-2:0], 1'b0};
            end
        end
        return d;
    endfunction

endpackage

// ===== rtl/core/srfr_engine.sv =====
// Exchange sequencer: holds the frame state and published words, and forms
// the result for each accepted item. Uses srfr_pkg and the assertion header.
`include "spi_request_frame_receiver_crc8_top_defines.svh"

module srfr_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  srfr_pkg::item_t   item,
    output srfr_pkg::result_t result
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FIRST = 2'd1,
        PH_BODY  = 2'd2
    } phase_t;

    phase_t                            phase_reg, phase_next;
    logic [srfr_pkg::KindW-1:0]        kind_reg, kind_next;
    logic [srfr_pkg::IndexW-1:0]       index_reg, index_next;
    logic [srfr_pkg::DataW-1:0]        crc_reg, crc_next;
    logic [srfr_pkg::DataW-1:0]        high_reg, high_next;
    logic [srfr_pkg::WordW-1:0]        left_reg, left_next;
    logic [srfr_pkg::WordW-1:0]        right_reg, right_next;
    logic [srfr_pkg::WordW-1:0]        volt_reg, volt_next;
    logic [srfr_pkg::WordW-1:0]        pend_reg, pend_next;
    logic [srfr_pkg::IndexW-1:0]       nbytes;
    logic [srfr_pkg::WordW-1:0]        word;

    assign nbytes = (kind_reg == srfr_pkg::KindThrottle) ? srfr_pkg::ThrottleBytes
                                                         : srfr_pkg::VoltageBytes;
    assign word = {high_reg, item.rx_byte};

    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        index_next = index_reg;
        crc_next   = crc_reg;
        high_next  = high_reg;
        left_next  = left_reg;
        right_next = right_reg;
        volt_next  = volt_reg;
        pend_next  = pend_reg;
        result.tx_byte    = srfr_pkg::TxIdle;
        result.frame_done = 1'b0;
        result.status     = srfr_pkg::StOk;

        if (item.command == srfr_pkg::CmdStart) begin
            // kind 3 is not a request: abort and go idle
            if (item.msg_kind == srfr_pkg::KindHello || item.msg_kind == srfr_pkg::KindThrottle
                || item.msg_kind == srfr_pkg::KindVoltage) begin
                phase_next = PH_FIRST;
                kind_next  = item.msg_kind;
                index_next = '0;
                crc_next   = '0;
                high_next  = '0;
                result.tx_byte = srfr_pkg::DataW'(item.msg_kind) + srfr_pkg::DataW'(1);
            end else begin
                phase_next = PH_IDLE;
            end
        end else begin
            case (phase_reg)
                PH_FIRST: begin
                    if (kind_reg == srfr_pkg::KindHello || item.rx_byte == srfr_pkg::RxAck) begin
                        phase_next = PH_BODY;
                        index_next = '0;
                        result.tx_byte = srfr_pkg::TxWait;
                    end else begin
                        phase_next = PH_IDLE;
                        result.frame_done = 1'b1;
                        result.status     = srfr_pkg::StNoAck;
                    end
                end
                PH_BODY: begin
                    if (kind_reg == srfr_pkg::KindHello) begin
                        phase_next = PH_IDLE;
                        result.frame_done = 1'b1;
                        result.status = (item.rx_byte == srfr_pkg::RxOk) ? srfr_pkg::StOk
                                                                        : srfr_pkg::StNoAck;
                    end else if (index_reg < nbytes) begin
                        crc_next = srfr_pkg::crc8_byte(crc_reg, item.rx_byte);
                        if (!index_reg[0]) begin
                            high_next = item.rx_byte;
                        end else if (kind_reg == srfr_pkg::KindVoltage) begin
                            pend_next = word;
                        end else if (index_reg == 3'd1) begin
                            left_next = word;
                        end else if (index_reg == 3'd3) begin
                            right_next = word;
                        end else begin
                            volt_next = word;
                        end
                        index_next = index_reg + 3'd1;
                        result.tx_byte = srfr_pkg::TxWait;
                    end else begin
                        // checksum byte
                        phase_next = PH_IDLE;
                        result.frame_done = 1'b1;
                        if (item.rx_byte == crc_reg) begin
                            result.status = srfr_pkg::StOk;
                            if (kind_reg == srfr_pkg::KindVoltage) begin
                                volt_next = pend_reg;
                            end
                        end else begin
                            result.status = srfr_pkg::StCrc;
                            if (kind_reg == srfr_pkg::KindThrottle) begin
                                left_next  = '0;
                                right_next = '0;
                                volt_next  = '0;
                            end
                        end
                    end
                end
                default: begin
                    // byte while idle is ignored
                end
            endcase
        end

        result.motor_left  = left_next;
        result.motor_right = right_next;
        result.voltage     = volt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            kind_reg  <= '0;
            index_reg <= '0;
            crc_reg   <= '0;
            high_reg  <= '0;
            left_reg  <= '0;
            right_reg <= '0;
            volt_reg  <= '0;
            pend_reg  <= '0;
        end else if (in_accept) begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            index_reg <= index_next;
            crc_reg   <= crc_next;
            high_reg  <= high_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            volt_reg  <= volt_next;
            pend_reg  <= pend_next;
        end
    end

    `SRFR_ASSERT_NEXT(a_done_goes_idle, aclk, aresetn, in_accept && result.frame_done, phase_reg == PH_IDLE)
    `SRFR_ASSERT_IMPL(a_status_only_when_done, aclk, aresetn, result.status != srfr_pkg::StOk, result.frame_done)
    `SRFR_ASSERT_IMPL(a_index_in_range, aclk, aresetn, phase_reg == PH_BODY, index_reg <= srfr_pkg::ThrottleBytes)
    `SRFR_ASSERT_NEXT(a_idle_byte_keeps_words, aclk, aresetn, in_accept && phase_reg == PH_IDLE && item.command == srfr_pkg::CmdByte, $stable(left_reg) && $stable(volt_reg))

endmodule

// ===== rtl/core/srfr_out_reg.sv =====
// Result register between the sequencer and the output channel.
// Uses srfr_pkg.
module srfr_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  srfr_pkg::result_t result,
    input  logic              m_tready,
    output logic              m_tvalid,
    output srfr_pkg::result_t held,
    output logic              can_load
);

    logic              valid_reg;
    srfr_pkg::result_t data_reg;

    // a waiting result that is being taken frees the register this cycle
    assign can_load = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign held     = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

// ===== rtl/core/spi_request_frame_receiver_crc8_top.sv =====
// Top level of the SPI request/response frame receiver with CRC-8 check.
// Uses srfr_pkg, srfr_engine and srfr_out_reg.
//
//  port group   direction  carries
//  s_*          in         one item per received byte or start request
//  m_*          out        one result per item, m_tlast marks end of exchange
//
// One result per item; each result is registered in the output register.
// An item may be accepted every cycle; s_tready drops only while a result
// waits in the output register and m_tready is low.
// Reset (aresetn low, synchronous) returns the exchange to idle and clears
// all published words; the output register comes up empty.
module spi_request_frame_receiver_crc8_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [srfr_pkg::STdataW-1:0]   s_tdata,  // rx_byte[7:0]
    input  logic [srfr_pkg::STuserW-1:0]   s_tuser,  // command[0], msg_kind[2:1]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [srfr_pkg::MTdataW-1:0]   m_tdata,  // tx_byte[7:0], status[9:8],
                                                     // motor_left[25:10],
                                                     // motor_right[41:26],
                                                     // voltage[57:42], zeros above
    output logic                           m_tlast   // frame_done
);

    logic              in_accept;
    logic              can_load;
    srfr_pkg::item_t   item;
    srfr_pkg::result_t result;
    srfr_pkg::result_t held;

    assign s_tready  = can_load;
    assign in_accept = s_tvalid && can_load;

    assign item.command  = s_tuser[0];
    assign item.msg_kind = s_tuser[2:1];
    assign item.rx_byte  = s_tdata;

    srfr_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .item      (item),
        .result    (result)
    );

    srfr_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (in_accept),
        .result   (result),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .held     (held),
        .can_load (can_load)
    );

    assign m_tdata = {6'd0, held.voltage, held.motor_right, held.motor_left,
                      held.status, held.tx_byte};
    assign m_tlast = held.frame_done;

endmodule

// ===== tb/tb_spi_request_frame_receiver_crc8_top.sv =====
// Testbench for spi_request_frame_receiver_crc8_top: directed and random SPI exchanges with
// random stalls on both sides, checked item by item against a behavioural model of the block.
// Depends on srfr_pkg and the RTL of the block only.
module tb_spi_request_frame_receiver_crc8_top;

    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned PrintLimit = 40;
    localparam int unsigned DrainCycles = 8;

    // start kind that names no request
    localparam logic [srfr_pkg::KindW-1:0] KindBad = 2'd3;

    typedef enum logic [1:0] {LinkIdle, LinkFirst, LinkBody} link_phase_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [srfr_pkg::STdataW-1:0]   s_tdata = '0;
    logic [srfr_pkg::STuserW-1:0]   s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [srfr_pkg::MTdataW-1:0]   m_tdata;
    logic                           m_tlast;

    spi_request_frame_receiver_crc8_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Model state of the exchange
    link_phase_t                    link_phase;
    logic [srfr_pkg::KindW-1:0]     link_kind;
    logic [srfr_pkg::IndexW-1:0]    body_index;
    logic [srfr_pkg::DataW-1:0]     running_crc;
    logic [srfr_pkg::DataW-1:0]     word_high;
    logic [srfr_pkg::WordW-1:0]     left_word;
    logic [srfr_pkg::WordW-1:0]     right_word;
    logic [srfr_pkg::WordW-1:0]     volt_word;
    logic [srfr_pkg::WordW-1:0]     volt_pending;

    srfr_pkg::result_t  expected_replies[$];
    int unsigned        mismatches = 0;
    int unsigned        counted_items = 0;
    int unsigned        cycles = 0;
    int unsigned        sender_idle_pct = 0;
    int unsigned        receiver_idle_pct = 0;

    function automatic logic [srfr_pkg::DataW-1:0] crc8_next(
        input logic [srfr_pkg::DataW-1:0] acc,
        input logic [srfr_pkg::DataW-1:0] b);
        logic [srfr_pkg::DataW-1:0] r;
        r = acc ^ b;
        repeat (8) begin
            r = r[srfr_pkg::DataW-1] ? ({r[srfr_pkg::DataW-2:0], 1'b0} ^ srfr_pkg::CrcPoly)
                                     : {r[srfr_pkg::DataW-2:0], 1'b0};
        end
        return r;
    endfunction

    task automatic clear_exchange();
        link_phase   = LinkIdle;
        link_kind    = '0;
        body_index   = '0;
        running_crc  = '0;
        word_high    = '0;
        left_word    = '0;
        right_word   = '0;
        volt_word    = '0;
        volt_pending = '0;
    endtask

    // Advances the model by one item and returns the reply it should produce
    function automatic srfr_pkg::result_t exchange_step(
        input logic                        cmd,
        input logic [srfr_pkg::KindW-1:0]  mk,
        input logic [srfr_pkg::DataW-1:0]  rx);
        srfr_pkg::result_t              r;
        logic [srfr_pkg::IndexW-1:0]    nbytes;
        logic [srfr_pkg::WordW-1:0]     w;
        r = '0;
        r.tx_byte = srfr_pkg::TxIdle;
        r.status  = srfr_pkg::StOk;
        if (cmd == srfr_pkg::CmdStart) begin
            if (mk == srfr_pkg::KindHello || mk == srfr_pkg::KindThrottle
                || mk == srfr_pkg::KindVoltage) begin
                link_phase  = LinkFirst;
                link_kind   = mk;
                body_index  = '0;
                running_crc = '0;
                word_high   = '0;
                r.tx_byte   = {6'd0, mk} + 8'd1;
            end else begin
                link_phase = LinkIdle;
            end
        end else if (link_phase == LinkFirst) begin
            if (link_kind == srfr_pkg::KindHello || rx == srfr_pkg::RxAck) begin
                link_phase = LinkBody;
                body_index = '0;
                r.tx_byte  = srfr_pkg::TxWait;
            end else begin
                link_phase   = LinkIdle;
                r.frame_done = 1'b1;
                r.status     = srfr_pkg::StNoAck;
            end
        end else if (link_phase == LinkBody) begin
            nbytes = (link_kind == srfr_pkg::KindThrottle) ? srfr_pkg::ThrottleBytes
                                                          : srfr_pkg::VoltageBytes;
            if (link_kind == srfr_pkg::KindHello) begin
                link_phase   = LinkIdle;
                r.frame_done = 1'b1;
                r.status     = (rx == srfr_pkg::RxOk) ? srfr_pkg::StOk : srfr_pkg::StNoAck;
            end else if (body_index < nbytes) begin
                running_crc = crc8_next(running_crc, rx);
                if (!body_index[0]) begin
                    word_high = rx;
                end else begin
                    w = {word_high, rx};
                    if (link_kind == srfr_pkg::KindVoltage) volt_pending = w;
                    else if (body_index == 3'd1) left_word = w;
                    else if (body_index == 3'd3) right_word = w;
                    else volt_word = w;
                end
                body_index = body_index + 1'b1;
                r.tx_byte  = srfr_pkg::TxWait;
            end else begin
                link_phase   = LinkIdle;
                r.frame_done = 1'b1;
                if (rx == running_crc) begin
                    r.status = srfr_pkg::StOk;
                    if (link_kind == srfr_pkg::KindVoltage) volt_word = volt_pending;
                end else begin
                    r.status = srfr_pkg::StCrc;
                    // a corrupt throttle frame wipes every published word
                    if (link_kind == srfr_pkg::KindThrottle) begin
                        left_word  = '0;
                        right_word = '0;
                        volt_word  = '0;
                    end
                end
            end
        end
        r.motor_left  = left_word;
        r.motor_right = right_word;
        r.voltage     = volt_word;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PrintLimit)
            $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Entered and left just after a falling edge
    task automatic send_item(input logic cmd, input logic [srfr_pkg::KindW-1:0] mk,
                             input logic [srfr_pkg::DataW-1:0] rx);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {mk, cmd};
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        // bytes arriving while idle are ignored and do not count as traffic
        if (!(cmd == srfr_pkg::CmdByte && link_phase == LinkIdle)) counted_items++;
        expected_replies.push_back(exchange_step(cmd, mk, rx));
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge aclk) begin
        srfr_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("unexpected item", m_tdata, '0);
            end else begin
                want = expected_replies.pop_front();
                if (m_tdata[7:0] != want.tx_byte)
                    report_mismatch("tx_byte", 64'(m_tdata[7:0]), 64'(want.tx_byte));
                if (m_tlast != want.frame_done)
                    report_mismatch("frame_done", 64'(m_tlast), 64'(want.frame_done));
                if (m_tdata[9:8] != want.status)
                    report_mismatch("status", 64'(m_tdata[9:8]), 64'(want.status));
                if (m_tdata[25:10] != want.motor_left)
                    report_mismatch("motor_left", 64'(m_tdata[25:10]),
                                    64'(want.motor_left));
                if (m_tdata[41:26] != want.motor_right)
                    report_mismatch("motor_right", 64'(m_tdata[41:26]),
                                    64'(want.motor_right));
                if (m_tdata[57:42] != want.voltage)
                    report_mismatch("voltage", 64'(m_tdata[57:42]), 64'(want.voltage));
                if (m_tdata[63:58] != '0)
                    report_mismatch("tdata padding", 64'(m_tdata[63:58]), '0);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("TIMEOUT after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_hello();
        send_item(srfr_pkg::CmdStart, srfr_pkg::KindHello, 8'd0);
        send_item(srfr_pkg::CmdByte, srfr_pkg::KindHello, 8'd255);  // first reply is don't-care
        send_item(srfr_pkg::CmdByte, srfr_pkg::KindHello, srfr_pkg::RxOk);
    endtask

    task automatic test_throttle();
        logic [srfr_pkg::DataW-1:0] body[6];
        logic [srfr_pkg::DataW-1:0] crc;
        body = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h01};
        crc = '0;
        send_item(srfr_pkg::CmdStart, srfr_pkg::KindThrottle, 8'h00);
        send_item(srfr_pkg::CmdByte, srfr_pkg::KindHello, srfr_pkg::RxAck);
        foreach (body[i]) begin
            crc = crc8_next(crc, body[i]);
            send_item(srfr_pkg::CmdByte, srfr_pkg::KindVoltage, body[i]);
        end
        send_item(srfr_pkg::CmdByte, srfr_pkg::KindHello, crc);
    endtask

    task automatic test_voltage_bad_checksum();
        logic [srfr_pkg::DataW-1:0] crc;
        crc = crc8_next(crc8_next(8'h00, 8'h12), 8'h34);
        send_item(srfr_pkg::CmdStart, srfr_pkg::KindVoltage, 8'hA5);
        send_item(srfr_pkg::CmdByte, srfr_pkg::KindHello, srfr_pkg::RxAck);
        send_item(srfr_pkg::CmdByte, srfr_pkg::KindHello, 8'h12);
        send_item(srfr_pkg::CmdByte, srfr_pkg::KindHello, 8'h34);
        // previous voltage must survive the bad checksum
        send_item(srfr_pkg::CmdByte, srfr_pkg::KindHello, ~crc);
    endtask

    task automatic test_corners();
        send_item(srfr_pkg::CmdStart, srfr_pkg::KindThrottle, 8'h00);
        send_item(srfr_pkg::CmdByte, srfr_pkg::KindHello, srfr_pkg::TxWait);  // no acknowledge
        send_item(srfr_pkg::CmdByte, srfr_pkg::KindThrottle, 8'h5A);    // byte while idle
        send_item(srfr_pkg::CmdStart, srfr_pkg::KindThrottle, 8'h00);
        send_item(srfr_pkg::CmdStart, srfr_pkg::KindVoltage, 8'hFF);    // start while busy
        send_item(srfr_pkg::CmdByte, srfr_pkg::KindHello, srfr_pkg::RxAck);
        send_item(srfr_pkg::CmdStart, KindBad, 8'h00);                  // unknown kind aborts
    endtask

    task automatic random_exchange();
        int unsigned                    pick;
        int unsigned                    nbytes;
        logic [srfr_pkg::KindW-1:0]     k;
        logic [srfr_pkg::DataW-1:0]     crc;
        logic [srfr_pkg::DataW-1:0]     b;
        pick = $urandom_range(99);
        if (pick < 10) begin
            send_item(1'($urandom_range(1)), srfr_pkg::KindW'($urandom_range(3)),
                      srfr_pkg::DataW'($urandom_range(255)));
            return;
        end
        k = (pick < 25) ? srfr_pkg::KindHello
          : (pick < 65) ? srfr_pkg::KindThrottle : srfr_pkg::KindVoltage;
        send_item(srfr_pkg::CmdStart, k, srfr_pkg::DataW'($urandom_range(255)));
        if (k == srfr_pkg::KindHello) begin
            send_item(srfr_pkg::CmdByte, srfr_pkg::KindW'($urandom_range(3)),
                      srfr_pkg::DataW'($urandom_range(255)));
            send_item(srfr_pkg::CmdByte, srfr_pkg::KindW'($urandom_range(3)),
                      ($urandom_range(9) < 8) ? srfr_pkg::RxOk
                                              : srfr_pkg::DataW'($urandom_range(255)));
            return;
        end
        b = ($urandom_range(9) < 9) ? srfr_pkg::RxAck : srfr_pkg::DataW'($urandom_range(255));
        send_item(srfr_pkg::CmdByte, srfr_pkg::KindW'($urandom_range(3)), b);
        if (b != srfr_pkg::RxAck) return;
        nbytes = (k == srfr_pkg::KindThrottle) ? 6 : 2;
        crc = '0;
        for (int unsigned i = 0; i < nbytes; i++) begin
            if ($urandom_range(99) < 4) return;  // truncated frame, next start abandons it
            b = srfr_pkg::DataW'($urandom_range(255));
            crc = crc8_next(crc, b);
            send_item(srfr_pkg::CmdByte, srfr_pkg::KindW'($urandom_range(3)), b);
        end
        send_item(srfr_pkg::CmdByte, srfr_pkg::KindW'($urandom_range(3)),
                  ($urandom_range(9) < 8) ? crc : srfr_pkg::DataW'($urandom_range(255)));
    endtask

    task automatic test_random(input int unsigned n);
        int unsigned target;
        target = counted_items + n;
        while (counted_items < target) random_exchange();
    endtask

    initial begin
        clear_exchange();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        sender_idle_pct   = 35;
        receiver_idle_pct = 58;
        test_hello();
        test_throttle();
        test_voltage_bad_checksum();
        test_corners();
        test_random(170);

        sender_idle_pct   = 58;
        receiver_idle_pct = 35;
        test_random(170);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random(170);

        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
